[rtl/slp_pkg.sv]
`timescale 1ns / 1ps

package slp_pkg;

   // parse phases of the back end
   typedef enum logic [4:0] {
      PH_WS     = 5'b00001,
      PH_SIGNED = 5'b00010,
      PH_ZERO   = 5'b00100,
      PH_XSEEN  = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   // one classified character as it travels from front to back
   typedef struct packed {
      logic       start;
      logic [4:0] radix_init;
      logic [4:0] digit;
      logic       space;
      logic       sign;
      logic       minus;
      logic       zero;
      logic       x_char;
   } slp_char_type;

   localparam logic [4:0] NO_DIGIT   = 5'd31;
   localparam logic [4:0] RADIX_AUTO = 5'd0;
   localparam logic [4:0] RADIX_MIN  = 5'd2;
   localparam logic [4:0] RADIX_OCT  = 5'd8;
   localparam logic [4:0] RADIX_DEC  = 5'd10;
   localparam logic [4:0] RADIX_HEX  = 5'd16;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;

   localparam int FIFO_DEPTH = 4;

endpackage

[rtl/slp_front.sv]
`timescale 1ns / 1ps

module slp_front #(
   parameter int MAX_LEN = 4096,
   parameter int POS_W   = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 string_start,
   input  logic [7:0]           char_code,
   input  logic                 csr_wr_en,
   input  logic [4:0]           csr_wr_data,
   output slp_pkg::slp_char_type cls_out,
   output logic [POS_W-1:0]     pos_out
);
   import slp_pkg::*;

   logic [4:0]       radix_choice_ff;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] idx;
   logic [4:0]       radix_init;
   logic [4:0]       digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_choice_ff <= RADIX_AUTO;
         pos_ff          <= '0;
      end else begin
         if (csr_wr_en) begin
            radix_choice_ff <= csr_wr_data;
         end
         if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_comb begin
      idx    = string_start ? '0 : pos_ff;
      pos_in = (idx < POS_W'(MAX_LEN)) ? idx + POS_W'(1) : POS_W'(MAX_LEN);
   end

   always_comb begin
      if (radix_choice_ff < RADIX_MIN) begin
         radix_init = RADIX_AUTO;
      end else if (radix_choice_ff > RADIX_HEX) begin
         radix_init = RADIX_HEX;
      end else begin
         radix_init = radix_choice_ff;
      end
   end

   always_comb begin
      if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
         digit = 5'(char_code - CH_ZERO);
      end else if (char_code >= CH_LO_A && char_code <= CH_LO_F) begin
         digit = 5'(char_code - CH_LO_A) + RADIX_DEC;
      end else if (char_code >= CH_UP_A && char_code <= CH_UP_F) begin
         digit = 5'(char_code - CH_UP_A) + RADIX_DEC;
      end else begin
         digit = NO_DIGIT;
      end
   end

   always_comb begin
      cls_out.start      = string_start;
      cls_out.radix_init = radix_init;
      cls_out.digit      = digit;
      cls_out.space      = (char_code == CH_SPACE) ||
                           (char_code >= CH_TAB && char_code <= CH_CR);
      cls_out.sign       = (char_code == CH_MINUS) || (char_code == CH_PLUS);
      cls_out.minus      = (char_code == CH_MINUS);
      cls_out.zero       = (char_code == CH_ZERO);
      cls_out.x_char     = (char_code == CH_LO_X) || (char_code == CH_UP_X);
      pos_out            = idx;
   end

endmodule

[rtl/slp_fifo.sv]
`timescale 1ns / 1ps

module slp_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

[rtl/slp_back.sv]
`timescale 1ns / 1ps

module slp_back #(
   parameter int VALUE_BITS = 64,
   parameter int POS_W      = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  slp_pkg::slp_char_type item_cls,
   input  logic [POS_W-1:0]      item_pos,
   output logic                  item_take,
   output logic                  empty,
   input  logic                  pop,
   output logic [63:0]           parsed_value,
   output logic [12:0]           end_offset,
   output logic                  saturated
);
   import slp_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int PW = VALUE_BITS + 5;

   phase_type        phase_ff, phase_in;
   logic [VB-1:0]    mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic [4:0]       radix_ff, radix_in;
   logic             done_ff, done_in;

   logic             rsp_valid_ff;
   logic [63:0]      value_ff;
   logic [12:0]      end_ff;
   logic             sat_ff;

   phase_type        cur_phase;
   logic [VB-1:0]    cur_mag;
   logic             cur_neg;
   logic [4:0]       cur_radix;
   logic             ignore;

   logic [4:0]       step_radix;
   logic [4:0]       base;
   logic [PW-1:0]    prod;
   logic [PW-1:0]    limit;
   logic             step_stop;
   logic             step_ovf;

   logic             emit;
   logic [VB-1:0]    e_mag;
   logic [POS_W-1:0] e_end;
   logic             e_sat;
   logic             out_free;

   logic signed [VB-1:0] e_value;
   logic [POS_W+12:0]    e_end_wide;

   always_comb begin
      cur_phase  = item_cls.start ? PH_WS : phase_ff;
      cur_mag    = item_cls.start ? '0 : mag_ff;
      cur_neg    = item_cls.start ? 1'b0 : neg_ff;
      cur_radix  = item_cls.start ? item_cls.radix_init : radix_ff;
      ignore     = !item_cls.start && done_ff;

      // auto radix after a leading zero falls back to octal
      step_radix = (cur_radix == RADIX_AUTO) ? RADIX_OCT : cur_radix;
      base       = (cur_radix == RADIX_AUTO) ? RADIX_DEC : cur_radix;
      prod       = PW'(cur_mag) * PW'(step_radix) + PW'(item_cls.digit);
      limit      = (PW'(1) << (VB - 1)) - (cur_neg ? PW'(0) : PW'(1));
      step_stop  = (item_cls.digit >= step_radix);
      step_ovf   = (prod > limit);
   end

   always_comb begin
      phase_in = cur_phase;
      mag_in   = cur_mag;
      neg_in   = cur_neg;
      radix_in = cur_radix;
      done_in  = item_cls.start ? 1'b0 : done_ff;
      emit     = 1'b0;
      e_mag    = cur_mag;
      e_end    = item_pos;
      e_sat    = 1'b0;

      case (cur_phase)
         PH_WS, PH_SIGNED: begin
            if (cur_phase == PH_WS && item_cls.space) begin
               phase_in = PH_WS;
            end else if (cur_phase == PH_WS && item_cls.sign) begin
               neg_in   = item_cls.minus;
               phase_in = PH_SIGNED;
            end else if (item_cls.zero &&
                         (cur_radix == RADIX_AUTO || cur_radix == RADIX_HEX)) begin
               mag_in   = '0;
               phase_in = PH_ZERO;
            end else if (item_cls.digit < base) begin
               radix_in = base;
               mag_in   = VB'(item_cls.digit);
               phase_in = PH_DIGITS;
            end else begin
               // no digits at all
               emit  = 1'b1;
               e_mag = '0;
               e_end = '0;
            end
         end
         PH_ZERO, PH_XSEEN, PH_DIGITS: begin
            if (cur_phase == PH_ZERO && item_cls.x_char &&
                (cur_radix == RADIX_AUTO || cur_radix == RADIX_HEX)) begin
               radix_in = RADIX_HEX;
               phase_in = PH_XSEEN;
            end else if (cur_phase == PH_XSEEN && item_cls.digit == NO_DIGIT) begin
               // bare hex prefix: only the zero is consumed
               emit  = 1'b1;
               e_mag = '0;
               e_end = (item_pos != '0) ? item_pos - POS_W'(1) : '0;
            end else begin
               radix_in = step_radix;
               phase_in = PH_DIGITS;
               if (step_stop) begin
                  emit = 1'b1;
               end else if (step_ovf) begin
                  emit  = 1'b1;
                  e_sat = 1'b1;
               end else begin
                  mag_in = prod[VB-1:0];
               end
            end
         end
         default: begin
            phase_in = PH_WS;
         end
      endcase

      if (emit) begin
         done_in = 1'b1;
      end
   end

   assign out_free  = !rsp_valid_ff || pop;
   assign item_take = item_valid && (ignore || !emit || out_free);

   always_comb begin
      if (e_sat) begin
         e_value = cur_neg ? {1'b1, {(VB - 1){1'b0}}} : {1'b0, {(VB - 1){1'b1}}};
      end else begin
         e_value = cur_neg ? -e_mag : e_mag;
      end
      e_end_wide = {13'd0, e_end};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WS;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         radix_ff     <= RADIX_AUTO;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_take && !ignore) begin
            phase_ff <= phase_in;
            mag_ff   <= mag_in;
            neg_ff   <= neg_in;
            radix_ff <= radix_in;
            done_ff  <= done_in;
         end
         if (item_take && !ignore && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && !ignore && emit) begin
         value_ff <= 64'(e_value);
         end_ff   <= e_end_wide[12:0];
         sat_ff   <= e_sat;
      end
   end

   assign empty        = !rsp_valid_ff;
   assign parsed_value = value_ff;
   assign end_offset   = end_ff;
   assign saturated    = sat_ff;

endmodule

[rtl/string_to_long_parser_unit.sv]
`timescale 1ns / 1ps
// A number-ending character is queued, then parsed and its result registered, later when
// the queue holds items or a result waits to be popped. Throughput: one character per
// cycle while the queue is not full; the parse unit stalls on a number-ending character
// while a result waits to be popped. Its multiply-add and limit compare on the magnitude
// set the per-character step. A 4-entry queue decouples front and back.
// Reset (synchronous, active high): queue and result emptied, radix register auto,
// parser idle until the next request marked as a string start.
module string_to_long_parser_unit #(
   parameter int MAX_LEN    = 4096,
   parameter int VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_string_start,
   input  logic [7:0]  req_char_code,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_parsed_value,
   output logic [12:0] rsp_end_offset,
   output logic        rsp_saturated,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);
   import slp_pkg::*;

   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam int QW    = $bits(slp_char_type) + POS_W;

   slp_char_type     front_cls;
   logic [POS_W-1:0] front_pos;
   slp_char_type     back_cls;
   logic [POS_W-1:0] back_pos;
   logic             accept;
   logic             q_empty;
   logic             q_take;
   logic [QW-1:0]    q_rdata;

   assign accept = push && !full;

   slp_front #(
      .MAX_LEN (MAX_LEN),
      .POS_W   (POS_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .string_start (req_string_start),
      .char_code    (req_char_code),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .cls_out      (front_cls),
      .pos_out      (front_pos)
   );

   slp_fifo #(
      .DEPTH (FIFO_DEPTH),
      .WIDTH (QW)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({front_cls, front_pos}),
      .full  (full),
      .pop   (q_take),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign {back_cls, back_pos} = q_rdata;

   slp_back #(
      .VALUE_BITS (VALUE_BITS),
      .POS_W      (POS_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (!q_empty),
      .item_cls     (back_cls),
      .item_pos     (back_pos),
      .item_take    (q_take),
      .empty        (empty),
      .pop          (pop),
      .parsed_value (rsp_parsed_value),
      .end_offset   (rsp_end_offset),
      .saturated    (rsp_saturated)
   );

endmodule

[rtl/slp_checker.sv]
`timescale 1ns / 1ps

module slp_checker #(
   parameter int MAX_LEN    = 4096,
   parameter int VALUE_BITS = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [63:0] rsp_parsed_value,
   input logic [12:0] rsp_end_offset,
   input logic        rsp_saturated
);

   localparam logic signed [63:0] MAX_V = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] MIN_V = -MAX_V - 64'sd1;

   // reset drops any waiting result
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result left after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_parsed_value) &&
                         $stable(rsp_end_offset) && $stable(rsp_saturated))
      else $error("waiting result changed");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_saturated |->
         ($signed(rsp_parsed_value) == MAX_V) || ($signed(rsp_parsed_value) == MIN_V))
      else $error("saturated result is not an extreme");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ($signed(rsp_parsed_value) <= MAX_V) &&
                 ($signed(rsp_parsed_value) >= MIN_V))
      else $error("result outside value range");

   a_end_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (MAX_LEN > 8191) || (32'(rsp_end_offset) <= 32'(MAX_LEN)))
      else $error("end offset beyond maximum length");

endmodule

bind string_to_long_parser_unit slp_checker #(
   .MAX_LEN    (MAX_LEN),
   .VALUE_BITS (VALUE_BITS)
) u_slp_checker (
   .clock            (clock),
   .reset            (reset),
   .empty            (empty),
   .pop              (pop),
   .rsp_parsed_value (rsp_parsed_value),
   .rsp_end_offset   (rsp_end_offset),
   .rsp_saturated    (rsp_saturated)
);
